// File: hw/rtl/vfd_pkg.sv
// Package for the segment buffer controller: command codes, sizes, lookup tables
// and shared controller/datapath types. No dependencies.
package vfd_pkg;

  localparam int NumRows      = 11;
  localparam int BytesPerRow  = 3;
  localparam int NumSymbols   = 25;
  localparam int TextPos      = 10;
  localparam int BufBytes     = NumRows * BytesPerRow;
  localparam int AddrW        = $clog2(BufBytes + 1);

  localparam logic [7:0] CMD_REFRESH = 8'b1100_0000;
  localparam logic [7:0] CMD_LEDS    = 8'b0100_0001;

  typedef enum logic [3:0] {
    MODE_CHAR    = 4'd0,
    MODE_PUT     = 4'd1,
    MODE_SET     = 4'd2,
    MODE_CLR     = 4'd3,
    MODE_CLEAR   = 4'd4,
    MODE_BACKUP  = 4'd5,
    MODE_RESTORE = 4'd6,
    MODE_REFRESH = 4'd7,
    MODE_LEDS    = 4'd8
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,     // clearing pass of both buffers after reset
    ST_ERASE,    // read-modify-write sweep over text bytes
    ST_CHAR,     // two-byte OR into the text row
    ST_SYM,      // read-modify-write of one symbol at a time
    ST_FILL,     // clear / backup / restore sweep
    ST_REFRESH,
    ST_LEDS
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             seg_we;
    logic             bak_we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] raddr;
    logic [1:0]       wsrc;    // 0 zero, 1 rmw result, 2 copy from backup
    logic [7:0]       and_m;   // rmw: (rd & and_m) | or_m
    logic [7:0]       or_m;
    logic             bak_from_seg;
  } dp_cmd_t;

  localparam logic [1:0] WSRC_ZERO = 2'd0;
  localparam logic [1:0] WSRC_RMW  = 2'd1;
  localparam logic [1:0] WSRC_BAK  = 2'd2;

  function automatic logic [15:0] digit_pat(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0: r = 16'd28686; 4'd1: r = 16'd10248; 4'd2: r = 16'd24966;
      4'd3: r = 16'd24970; 4'd4: r = 16'd12680; 4'd5: r = 16'd20874;
      4'd6: r = 16'd20878; 4'd7: r = 16'd24584; 4'd8: r = 16'd29070;
      4'd9: r = 16'd29066;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] latin_pat(input logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0: r = 16'd29068;  5'd1: r = 16'd26026;  5'd2: r = 16'd20486;
      5'd3: r = 16'd25642;  5'd4: r = 16'd20870;  5'd5: r = 16'd20868;
      5'd6: r = 16'd20750;  5'd7: r = 16'd12684;  5'd8: r = 16'd17442;
      5'd9: r = 16'd8206;   5'd10: r = 16'd6340;  5'd11: r = 16'd4102;
      5'd12: r = 16'd14860; 5'd13: r = 16'd12876; 5'd14: r = 16'd28686;
      5'd15: r = 16'd29060; 5'd16: r = 16'd28750; 5'd17: r = 16'd29124;
      5'd18: r = 16'd20874; 5'd19: r = 16'd17440; 5'd20: r = 16'd12302;
      5'd21: r = 16'd6164;  5'd22: r = 16'd12380; 5'd23: r = 16'd2640;
      5'd24: r = 16'd2592;  5'd25: r = 16'd18450;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] cyr_pat(input logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0: r = 16'd29068;  5'd1: r = 16'd17834;  5'd2: r = 16'd26026;
      5'd3: r = 16'd20484;  5'd4: r = 16'd25642;  5'd5: r = 16'd20870;
      5'd6: r = 16'd3696;   5'd7: r = 16'd18698;  5'd8: r = 16'd14364;
      5'd9: r = 16'd14364;  5'd10: r = 16'd6340;  5'd11: r = 16'd10264;
      5'd12: r = 16'd14860; 5'd13: r = 16'd12684; 5'd14: r = 16'd28686;
      5'd15: r = 16'd28684; 5'd16: r = 16'd29060; 5'd17: r = 16'd20486;
      5'd18: r = 16'd17440; 5'd19: r = 16'd12682; 5'd20: r = 16'd30112;
      5'd21: r = 16'd2640;  5'd22: r = 16'd12366; 5'd23: r = 16'd12680;
      5'd24: r = 16'd13358; 5'd25: r = 16'd13422; 5'd26: r = 16'd4244;
      5'd27: r = 16'd12444; 5'd28: r = 16'd4244;  5'd29: r = 16'd24842;
      5'd30: r = 16'd14540; 5'd31: r = 16'd29080;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // specials, searched before the Latin range
  function automatic logic spec_pat(input logic [7:0] c, output logic [15:0] p);
    logic hit;
    hit = 1'b1;
    unique case (c)
      8'd33:  p = 16'd19970; 8'd63:  p = 16'd24864; 8'd42:  p = 16'd4080;
      8'd43:  p = 16'd1440;  8'd45:  p = 16'd384;   8'd95:  p = 16'd2;
      8'd39:  p = 16'd2048;  8'd34:  p = 16'd9216;  8'd37:  p = 16'd7128;
      8'd40:  p = 16'd2112;  8'd41:  p = 16'd528;   8'd36:  p = 16'd21930;
      8'd47:  p = 16'd2064;  8'd124: p = 16'd1056;  8'd92:  p = 16'd576;
      8'd38:  p = 16'd19034; 8'd64:  p = 16'd29958; 8'd176: p = 16'd29056;
      8'd100: p = 16'd8590;  8'd60:  p = 16'd2112;  8'd62:  p = 16'd528;
      8'd177: p = 16'd1442;  8'd104: p = 16'd4492;  8'd44:  p = 16'd16;
      8'd46:  p = 16'd32;    8'd97:  p = 16'd24974;
      default: begin
        p = 16'd0;
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  function automatic logic [15:0] lookup_char(input logic [7:0] c);
    logic [15:0] sp;
    logic        hit;
    logic [7:0]  d;
    logic [15:0] r;
    hit = spec_pat(c, sp);
    d = c - 8'd48;
    if (c >= 8'd48 && c <= 8'd57)      r = digit_pat(d[3:0]);
    else if (c <= 8'd9)                r = digit_pat(c[3:0]);
    else if (hit)                      r = sp;
    else if (c >= 8'd97 && c <= 8'd122) r = latin_pat(5'(c - 8'd97));
    else if (c >= 8'd65 && c <= 8'd90)  r = latin_pat(5'(c - 8'd65));
    else if (c >= 8'd192)              r = cyr_pat(c[4:0]);
    else                               r = 16'd0;
    return r;
  endfunction

  // symbol n: {row, bit within 24-bit row word}
  function automatic logic [9:0] sym_place(input logic [4:0] n);
    logic [9:0] r;
    unique case (n)
      5'd0: r = {5'd1, 5'd16};  5'd1: r = {5'd1, 5'd15};  5'd2: r = {5'd2, 5'd16};
      5'd3: r = {5'd2, 5'd15};  5'd4: r = {5'd3, 5'd16};  5'd5: r = {5'd3, 5'd15};
      5'd6: r = {5'd4, 5'd16};  5'd7: r = {5'd4, 5'd15};  5'd8: r = {5'd5, 5'd16};
      5'd9: r = {5'd5, 5'd15};  5'd10: r = {5'd6, 5'd16}; 5'd11: r = {5'd6, 5'd15};
      5'd12: r = {5'd8, 5'd16}; 5'd13: r = {5'd8, 5'd15}; 5'd14: r = {5'd9, 5'd16};
      5'd15: r = {5'd10, 5'd16}; 5'd16: r = {5'd10, 5'd15}; 5'd17: r = {5'd0, 5'd0};
      5'd18: r = {5'd0, 5'd1};  5'd19: r = {5'd0, 5'd4};  5'd20: r = {5'd0, 5'd3};
      5'd21: r = {5'd0, 5'd5};  5'd22: r = {5'd0, 5'd2};  5'd23: r = {5'd0, 5'd6};
      5'd24: r = {5'd6, 5'd0};
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/vfd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module vfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/vfd_datapath.sv
// Datapath: segment and backup RAMs, read-modify-write and copy paths.
// Depends on vfd_pkg and vfd_ram.
module vfd_datapath (
  input  logic              clk,
  input  vfd_pkg::dp_cmd_t  cmd,
  output logic [7:0]        seg_rd
);
  localparam int AW = $clog2(vfd_pkg::BufBytes);

  logic [7:0] bak_rd;
  logic [7:0] seg_wdata;
  logic [7:0] bak_wdata;

  always_comb begin
    unique case (cmd.wsrc)
      vfd_pkg::WSRC_RMW: seg_wdata = (seg_rd & cmd.and_m) | cmd.or_m;
      vfd_pkg::WSRC_BAK: seg_wdata = bak_rd;
      default:           seg_wdata = 8'd0;
    endcase
    bak_wdata = cmd.bak_from_seg ? seg_rd : 8'd0;
  end

  vfd_ram #(.Width(8), .Depth(vfd_pkg::BufBytes)) u_seg (
    .clk, .we(cmd.seg_we), .waddr(cmd.waddr[AW-1:0]), .wdata(seg_wdata),
    .raddr(cmd.raddr[AW-1:0]), .rdata(seg_rd)
  );

  vfd_ram #(.Width(8), .Depth(vfd_pkg::BufBytes)) u_bak (
    .clk, .we(cmd.bak_we), .waddr(cmd.waddr[AW-1:0]), .wdata(bak_wdata),
    .raddr(cmd.raddr[AW-1:0]), .rdata(bak_rd)
  );
endmodule

// File: hw/rtl/vfd_ctrl.sv
// Controller: command sequencer driving the datapath and the byte stream.
// Depends on vfd_pkg.
module vfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        mode,
  input  logic [7:0]        char_code,
  input  logic              string_start,
  input  logic [24:0]       symbol_mask,
  input  logic [3:0]        led_mask,
  output logic [7:0]        spi_byte,
  output logic              frame_last,
  output logic              strobe,
  output vfd_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        seg_rd
);
  localparam int AW = vfd_pkg::AddrW;

  vfd_pkg::state_t state, state_next;
  logic [AW-1:0] cnt, cnt_next;         // address / step counter
  logic          ph, ph_next;           // rmw phase: 0 read, 1 write
  logic          hi, hi_next;           // erase: 0 byte0, 1 byte1 of the row
  logic [3:0]    text_pos, text_pos_next;
  logic [3:0]    op, op_next;
  logic [7:0]    ch, ch_next;
  logic [24:0]   mask, mask_next;
  logic [3:0]    leds, leds_next;
  logic [15:0]   pat;
  logic [9:0]    place;
  logic [AW-1:0] sym_idx;
  logic [7:0]    sym_bit;
  logic [AW-1:0] row_base;
  logic [7:0]    out_byte, out_byte_next;
  logic          out_last, out_last_next;
  logic          out_stb, out_stb_next;

  assign pat = vfd_pkg::lookup_char(ch);
  assign place = vfd_pkg::sym_place(cnt[4:0]);
  assign sym_idx = AW'(place[9:5] * 5'd3) + AW'(place[4:3]);
  assign sym_bit = 8'd1 << place[2:0];
  assign row_base = AW'(text_pos * 3'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vfd_pkg::ST_INIT;
      cnt <= '0;
      ph <= 1'b0;
      hi <= 1'b0;
      text_pos <= 4'(vfd_pkg::TextPos);
      out_stb <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ph <= ph_next;
      hi <= hi_next;
      text_pos <= text_pos_next;
      out_stb <= out_stb_next;
    end
    op <= op_next;
    ch <= ch_next;
    mask <= mask_next;
    leds <= leds_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
  end

  assign spi_byte = out_byte;
  assign frame_last = out_last;
  assign strobe = out_stb;
  assign busy = (state != vfd_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ph_next = ph;
    hi_next = hi;
    text_pos_next = text_pos;
    op_next = op;
    ch_next = ch;
    mask_next = mask;
    leds_next = leds;
    out_byte_next = out_byte;
    out_last_next = 1'b0;
    out_stb_next = 1'b0;
    cmd = '0;
    cmd.raddr = cnt;
    cmd.waddr = cnt;
    cmd.and_m = 8'hFF;
    unique case (state)
      vfd_pkg::ST_IDLE: begin
        if (start) begin
          op_next = mode;
          ch_next = char_code;
          mask_next = symbol_mask;
          leds_next = led_mask;
          cnt_next = '0;
          ph_next = 1'b0;
          hi_next = 1'b0;
          unique case (mode)
            vfd_pkg::MODE_CHAR: begin
              if (string_start) begin
                state_next = vfd_pkg::ST_ERASE;
                cnt_next = AW'(3);
              end else if (char_code == 8'd0) begin
                text_pos_next = '0;
              end else if (text_pos != 4'd0) begin
                state_next = vfd_pkg::ST_CHAR;
              end
            end
            vfd_pkg::MODE_PUT, vfd_pkg::MODE_SET,
            vfd_pkg::MODE_CLR:     state_next = vfd_pkg::ST_SYM;
            vfd_pkg::MODE_CLEAR, vfd_pkg::MODE_BACKUP,
            vfd_pkg::MODE_RESTORE: state_next = vfd_pkg::ST_FILL;
            vfd_pkg::MODE_REFRESH: state_next = vfd_pkg::ST_REFRESH;
            vfd_pkg::MODE_LEDS:    state_next = vfd_pkg::ST_LEDS;
            default: ;
          endcase
        end
      end
      vfd_pkg::ST_INIT: begin
        cmd.seg_we = 1'b1;
        cmd.bak_we = 1'b1;
        cmd.wsrc = vfd_pkg::WSRC_ZERO;
        cnt_next = cnt + 1'b1;
        if (cnt == AW'(vfd_pkg::BufBytes - 1)) state_next = vfd_pkg::ST_IDLE;
      end
      vfd_pkg::ST_ERASE: begin
        // bytes 3..3*TextPos+1: keep bit 0 of byte0, bit 7 of byte1
        ph_next = ~ph;
        if (ph) begin
          cmd.seg_we = 1'b1;
          cmd.wsrc = vfd_pkg::WSRC_RMW;
          cmd.and_m = hi ? 8'h80 : 8'h01;
          cnt_next = hi ? cnt + 2'd2 : cnt + 1'b1;
          hi_next = ~hi;
          if (cnt == AW'(vfd_pkg::TextPos * 3 + 1)) begin
            text_pos_next = 4'(vfd_pkg::TextPos);
            cnt_next = '0;
            ph_next = 1'b0;
            hi_next = 1'b0;
            state_next = (ch == 8'd0) ? vfd_pkg::ST_IDLE : vfd_pkg::ST_CHAR;
            if (ch == 8'd0) text_pos_next = '0;
          end
        end
      end
      vfd_pkg::ST_CHAR: begin
        // cnt[0] selects byte; ph read / write
        cmd.raddr = row_base + AW'(cnt[0]);
        cmd.waddr = cmd.raddr;
        ph_next = ~ph;
        if (ph) begin
          cmd.seg_we = 1'b1;
          cmd.wsrc = vfd_pkg::WSRC_RMW;
          cmd.or_m = cnt[0] ? {1'b0, pat[14:8]} : {pat[7:1], 1'b0};
          cnt_next = cnt + 1'b1;
          if (cnt[0]) begin
            text_pos_next = text_pos - 1'b1;
            state_next = vfd_pkg::ST_IDLE;
          end
        end
      end
      vfd_pkg::ST_SYM: begin
        cmd.raddr = sym_idx;
        cmd.waddr = sym_idx;
        ph_next = ~ph;
        if (ph) begin
          cnt_next = cnt + 1'b1;
          cmd.wsrc = vfd_pkg::WSRC_RMW;
          if (op == vfd_pkg::MODE_CLR) begin
            cmd.seg_we = mask[cnt[4:0]];
            cmd.and_m = ~sym_bit;
          end else if (mask[cnt[4:0]]) begin
            cmd.seg_we = 1'b1;
            cmd.or_m = sym_bit;
          end else begin
            cmd.seg_we = (op == vfd_pkg::MODE_PUT);
            cmd.and_m = ~sym_bit;
          end
          if (cnt == AW'(vfd_pkg::NumSymbols - 1)) state_next = vfd_pkg::ST_IDLE;
        end
      end
      vfd_pkg::ST_FILL: begin
        // backup reads seg then writes it in the next cycle; restore likewise
        ph_next = ~ph;
        if (ph) begin
          cnt_next = cnt + 1'b1;
          if (op == vfd_pkg::MODE_BACKUP) begin
            cmd.bak_we = 1'b1;
            cmd.bak_from_seg = 1'b1;
          end else begin
            cmd.seg_we = 1'b1;
            cmd.wsrc = (op == vfd_pkg::MODE_RESTORE) ? vfd_pkg::WSRC_BAK
                                                      : vfd_pkg::WSRC_ZERO;
          end
          if (cnt == AW'(vfd_pkg::BufBytes - 1)) state_next = vfd_pkg::ST_IDLE;
        end
      end
      vfd_pkg::ST_REFRESH: begin
        // cnt issues the read address; seg_rd already holds the data of address cnt-1
        cmd.raddr = cnt;
        cnt_next = cnt + 1'b1;
        out_stb_next = 1'b1;
        if (!ph) begin
          out_byte_next = vfd_pkg::CMD_REFRESH;
          ph_next = 1'b1;
          cnt_next = AW'(1);
          cmd.raddr = '0;
        end else begin
          out_byte_next = seg_rd;
          cmd.raddr = cnt;
          if (cnt == AW'(vfd_pkg::BufBytes)) begin
            out_last_next = 1'b1;
            state_next = vfd_pkg::ST_IDLE;
            ph_next = 1'b0;
            cnt_next = '0;
            cmd.raddr = '0;
          end
        end
      end
      vfd_pkg::ST_LEDS: begin
        out_stb_next = 1'b1;
        ph_next = ~ph;
        if (!ph) begin
          out_byte_next = vfd_pkg::CMD_LEDS;
        end else begin
          out_byte_next = {4'd0, ~leds};
          out_last_next = 1'b1;
          state_next = vfd_pkg::ST_IDLE;
        end
      end
      default: state_next = vfd_pkg::ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    frame_last |-> strobe) else $error("frame_last without strobe");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == vfd_pkg::ST_IDLE) |-> !(cmd.seg_we || cmd.bak_we))
    else $error("buffer write while idle");
  a_textpos: assert property (@(posedge clk) disable iff (rst)
    text_pos <= 4'(vfd_pkg::TextPos)) else $error("text position out of range");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    frame_last |-> (state == vfd_pkg::ST_IDLE)) else $error("busy after last byte");
`endif
endmodule

// File: hw/rtl/vfd_segment_buffer_controller_core.sv
// Top level of the display segment buffer controller.
// Depends on vfd_pkg, vfd_ctrl, vfd_datapath (and vfd_ram through it).
//
// A command is taken when start is high and busy low. After reset a
// clearing pass of both buffers runs with busy high. Each word goes out on
// spi_byte/frame_last for one cycle under strobe; the receiver cannot stall.
// Buffer updates follow the single read and write port of the buffer RAMs: a byte
// is read, then written. A character writes two bytes (plus the erase on a string
// start); symbols and clear/backup/restore sweep alike; refresh sends 34 words, LEDs 2.
module vfd_segment_buffer_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode,
  input  logic [7:0]  char_code,
  input  logic        string_start,
  input  logic [24:0] symbol_mask,
  input  logic [3:0]  led_mask,
  output logic        strobe,
  output logic [7:0]  spi_byte,
  output logic        frame_last
);
  vfd_pkg::dp_cmd_t cmd;
  logic [7:0] seg_rd;

  vfd_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .mode, .char_code, .string_start, .symbol_mask,
    .led_mask, .spi_byte, .frame_last, .strobe, .cmd, .seg_rd
  );

  vfd_datapath u_dp (.clk, .cmd, .seg_rd);
endmodule

// File: sim/vfd_scoreboard.sv
// Checker for the segment buffer controller: models the buffers, predicts each
// SPI word from accepted commands and compares it with the strobed output.
// Depends on vfd_pkg for the mode codes and sizes.
module vfd_scoreboard
  import vfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [3:0]  mode,
  input  logic [7:0]  char_code,
  input  logic        string_start,
  input  logic [24:0] symbol_mask,
  input  logic [3:0]  led_mask,
  input  logic        strobe,
  input  logic [7:0]  spi_byte,
  input  logic        frame_last,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } spi_word_t;

  localparam logic [15:0] DIGITS [10] = '{
    16'd28686, 16'd10248, 16'd24966, 16'd24970, 16'd12680,
    16'd20874, 16'd20878, 16'd24584, 16'd29070, 16'd29066};
  localparam logic [15:0] LATIN [26] = '{
    16'd29068, 16'd26026, 16'd20486, 16'd25642, 16'd20870, 16'd20868, 16'd20750,
    16'd12684, 16'd17442, 16'd8206, 16'd6340, 16'd4102, 16'd14860, 16'd12876,
    16'd28686, 16'd29060, 16'd28750, 16'd29124, 16'd20874, 16'd17440, 16'd12302,
    16'd6164, 16'd12380, 16'd2640, 16'd2592, 16'd18450};
  localparam logic [15:0] CYRIL [32] = '{
    16'd29068, 16'd17834, 16'd26026, 16'd20484, 16'd25642, 16'd20870, 16'd3696,
    16'd18698, 16'd14364, 16'd14364, 16'd6340, 16'd10264, 16'd14860, 16'd12684,
    16'd28686, 16'd28684, 16'd29060, 16'd20486, 16'd17440, 16'd12682, 16'd30112,
    16'd2640, 16'd12366, 16'd12680, 16'd13358, 16'd13422, 16'd4244, 16'd12444,
    16'd4244, 16'd24842, 16'd14540, 16'd29080};
  localparam logic [7:0] SPEC_CODE [26] = '{
    8'd33, 8'd63, 8'd42, 8'd43, 8'd45, 8'd95, 8'd39, 8'd34, 8'd37, 8'd40, 8'd41,
    8'd36, 8'd47, 8'd124, 8'd92, 8'd38, 8'd64, 8'd176, 8'd100, 8'd60, 8'd62,
    8'd177, 8'd104, 8'd44, 8'd46, 8'd97};
  localparam logic [15:0] SPEC_GLYPH [26] = '{
    16'd19970, 16'd24864, 16'd4080, 16'd1440, 16'd384, 16'd2, 16'd2048, 16'd9216,
    16'd7128, 16'd2112, 16'd528, 16'd21930, 16'd2064, 16'd1056, 16'd576,
    16'd19034, 16'd29958, 16'd29056, 16'd8590, 16'd2112, 16'd528, 16'd1442,
    16'd4492, 16'd16, 16'd32, 16'd24974};
  // {row, bit in 24-bit row word}
  localparam int MARK_ROW [25] = '{1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6, 8, 8, 9,
                                   10, 10, 0, 0, 0, 0, 0, 0, 0, 6};
  localparam int MARK_BIT [25] = '{16, 15, 16, 15, 16, 15, 16, 15, 16, 15, 16,
                                   15, 16, 15, 16, 16, 15, 0, 1, 4, 3, 5, 2, 6, 0};

  logic [7:0] seg_model [BufBytes];
  logic [7:0] bak_model [BufBytes];
  logic [3:0] text_row;
  spi_word_t  spi_expected [$];

  function automatic logic [15:0] glyph_of(input logic [7:0] c);
    if (c >= 8'd48 && c <= 8'd57) return DIGITS[c - 8'd48];
    if (c <= 8'd9) return DIGITS[c];
    for (int i = 0; i < 26; i++)
      if (SPEC_CODE[i] == c) return SPEC_GLYPH[i];
    if (c >= 8'd97 && c <= 8'd122) return LATIN[c - 8'd97];
    if (c >= 8'd65 && c <= 8'd90) return LATIN[c - 8'd65];
    if (c >= 8'd192) return CYRIL[c[4:0]];
    return 16'd0;
  endfunction

  // put: set & clear, set: set only, clr: clear where mask bit is high
  task automatic mark_symbols(input logic [24:0] m, input logic do_set, input logic do_clr);
    int idx;
    for (int i = 0; i < NumSymbols; i++) begin
      idx = MARK_ROW[i] * BytesPerRow + MARK_BIT[i] / 8;
      if (m[i]) begin
        if (do_set) seg_model[idx][MARK_BIT[i] % 8] = 1'b1;
      end else if (do_clr) begin
        seg_model[idx][MARK_BIT[i] % 8] = 1'b0;
      end
    end
  endtask

  task automatic write_char(input logic [7:0] c, input logic first);
    logic [15:0] g;
    int base;
    if (first) begin
      for (int r = 1; r <= TextPos; r++) begin
        seg_model[r * BytesPerRow] &= 8'h01;
        seg_model[r * BytesPerRow + 1] &= 8'h80;
      end
      text_row = 4'(TextPos);
    end
    if (c == 8'd0) begin
      text_row = 4'd0;
    end else if (text_row != 0 && text_row <= TextPos) begin
      g = glyph_of(c);
      base = text_row * BytesPerRow;
      seg_model[base] |= g[7:0] & 8'hFE;
      seg_model[base + 1] |= g[15:8] & 8'h7F;
      text_row--;
    end
  endtask

  task automatic report(input string what, input logic [7:0] got_d, input logic got_l,
                        input logic [7:0] exp_d, input logic exp_l);
    $display("%0t mismatch (%s): got %02h/%0b, expected %02h/%0b",
             $realtime, what, got_d, got_l, exp_d, exp_l);
    fail_count++;
  endtask

  assign words_pending = spi_expected.size();

  always @(posedge clk) begin
    spi_word_t w;
    if (rst) begin
      for (int i = 0; i < BufBytes; i++) begin
        seg_model[i] = 8'h00;
        bak_model[i] = 8'h00;
      end
      text_row = 4'(TextPos);
      fail_count = 0;
      spi_expected.delete();
    end else begin
      if (strobe) begin
        if (spi_expected.size() == 0) begin
          report("unexpected word", spi_byte, frame_last, 8'h00, 1'b0);
        end else begin
          w = spi_expected.pop_front();
          if (spi_byte !== w.data) report("spi_byte", spi_byte, frame_last, w.data, w.last);
          if (frame_last !== w.last)
            report("frame_last", spi_byte, frame_last, w.data, w.last);
        end
      end
      if (start && !busy) begin
        case (mode)
          MODE_CHAR:    write_char(char_code, string_start);
          MODE_PUT:     mark_symbols(symbol_mask, 1'b1, 1'b1);
          MODE_SET:     mark_symbols(symbol_mask, 1'b1, 1'b0);
          MODE_CLR:     mark_symbols(~symbol_mask, 1'b0, 1'b1);
          MODE_CLEAR:   for (int i = 0; i < BufBytes; i++) seg_model[i] = 8'h00;
          MODE_BACKUP:  for (int i = 0; i < BufBytes; i++) bak_model[i] = seg_model[i];
          MODE_RESTORE: for (int i = 0; i < BufBytes; i++) seg_model[i] = bak_model[i];
          MODE_REFRESH: begin
            spi_expected.push_back('{CMD_REFRESH, 1'b0});
            for (int i = 0; i < BufBytes; i++)
              spi_expected.push_back('{seg_model[i], i == BufBytes - 1});
          end
          MODE_LEDS: begin
            spi_expected.push_back('{CMD_LEDS, 1'b0});
            spi_expected.push_back('{{4'h0, ~led_mask}, 1'b1});
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sim/tb_vfd_segment_buffer_controller_core.sv
// Testbench top for the segment buffer controller: drives directed and random
// commands, hosts the checker and gives the verdict.
// Depends on vfd_pkg, vfd_segment_buffer_controller_core and vfd_scoreboard.
module tb_vfd_segment_buffer_controller_core;
  import vfd_pkg::*;

  localparam int WatchdogLimit = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  mode = 4'd0;
  logic [7:0]  char_code = 8'd0;
  logic        string_start = 1'b0;
  logic [24:0] symbol_mask = 25'd0;
  logic [3:0]  led_mask = 4'd0;
  logic        strobe;
  logic [7:0]  spi_byte;
  logic        frame_last;
  int          fail_count;
  int          words_pending;
  int          quiet_cycles = 0;
  logic        busy_gaps = 1'b1;

  always #4 clk = ~clk;

  vfd_segment_buffer_controller_core u_top (.*);

  vfd_scoreboard u_chk (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic issue(input mode_t m, input logic [7:0] c, input logic first,
                       input logic [24:0] syms, input logic [3:0] leds);
    int gap;
    gap = busy_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= m;
    char_code    <= c;
    string_start <= first;
    symbol_mask  <= syms;
    led_mask     <= leds;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic send_text(input logic [7:0] c, input logic first);
    issue(MODE_CHAR, c, first, 25'($urandom), 4'($urandom));
  endtask

  initial begin
    int n_words;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: every table, terminator, overflow, marks, LEDs and spare modes
    issue(MODE_REFRESH, 8'd0, 1'b0, 25'd0, 4'd0);
    send_text(8'd0, 1'b1);
    send_text(8'd7, 1'b1);
    send_text("5", 1'b0);
    send_text("a", 1'b0);
    send_text("d", 1'b0);
    send_text("h", 1'b0);
    send_text(8'd176, 1'b0);
    send_text(8'd177, 1'b0);
    send_text("Z", 1'b0);
    send_text(8'd192, 1'b0);
    send_text(8'd255, 1'b0);
    send_text(8'd128, 1'b0);
    issue(MODE_REFRESH, 8'd0, 1'b0, 25'd0, 4'd0);
    issue(MODE_PUT, 8'd0, 1'b0, 25'h1FFFFFF, 4'd0);
    issue(MODE_BACKUP, 8'd0, 1'b0, 25'd0, 4'd0);
    issue(MODE_CLR, 8'd0, 1'b0, 25'h0AAAAAA, 4'd0);
    issue(MODE_REFRESH, 8'd0, 1'b0, 25'd0, 4'd0);
    issue(MODE_CLEAR, 8'd0, 1'b0, 25'd0, 4'd0);
    issue(MODE_SET, 8'd0, 1'b0, 25'h1555555, 4'd0);
    issue(MODE_RESTORE, 8'd0, 1'b0, 25'd0, 4'd0);
    issue(MODE_REFRESH, 8'd0, 1'b0, 25'd0, 4'd0);
    issue(MODE_LEDS, 8'd0, 1'b0, 25'd0, 4'h0);
    issue(MODE_LEDS, 8'd0, 1'b0, 25'd0, 4'hF);
    issue(mode_t'(4'd9), 8'd0, 1'b0, 25'd0, 4'd0);
    issue(mode_t'(4'd15), 8'd0, 1'b0, 25'd0, 4'd0);

    // random: whole strings with random content, mixed with other commands
    n_words = 0;
    while (n_words < 245) begin
      if ($urandom_range(0, 9) == 0) busy_gaps = ~busy_gaps;
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        send_text(8'($urandom_range(1, 255)), 1'b1);
        repeat ($urandom_range(0, 12)) begin
          send_text($urandom_range(0, 15) == 0 ? 8'd0 : 8'($urandom_range(1, 255)), 1'b0);
          n_words++;
        end
      end else if (pick < 8) begin
        send_text(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 13) begin
        issue(mode_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
              25'($urandom), 4'($urandom));
      end else if (pick < 15) begin
        issue(mode_t'($urandom_range(4, 6)), 8'($urandom), 1'($urandom),
              25'($urandom), 4'($urandom));
      end else if (pick < 17) begin
        issue(MODE_REFRESH, 8'($urandom), 1'($urandom), 25'($urandom), 4'($urandom));
      end else if (pick < 19) begin
        issue(MODE_LEDS, 8'($urandom), 1'($urandom), 25'($urandom), 4'($urandom));
      end else begin
        issue(mode_t'($urandom_range(9, 15)), 8'($urandom), 1'($urandom),
              25'($urandom), 4'($urandom));
        n_words--;
      end
      n_words++;
    end
    start <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
